@@ rtl/mqtt_df_pkg.sv @@
// ---------------------------------------------------------------------------
// MQTT deframer package
// Shared types and constants for the inbound packet deframer.
// ---------------------------------------------------------------------------
package mqtt_df_pkg;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_LENGTH   = 3'd1,
    PH_TOPIC_HI = 3'd2,
    PH_TOPIC_LO = 3'd3,
    PH_TOPIC    = 3'd4,
    PH_PAYLOAD  = 3'd5,
    PH_SKIP     = 3'd6
  } mqtt_df_phase_t;

  typedef enum logic [1:0] {
    ROLE_HEADER  = 2'd0,
    ROLE_TOPIC   = 2'd1,
    ROLE_PAYLOAD = 2'd2,
    ROLE_SKIP    = 2'd3
  } mqtt_df_role_t;

  localparam logic [3:0] PUBLISH_TYPE = 4'd3;
  localparam int unsigned BODY_W = 28;

  typedef struct packed {
    logic [7:0]    out_byte;
    mqtt_df_role_t byte_role;
    logic [3:0]    packet_type;
    logic [3:0]    packet_flags;
    logic          end_of_packet;
    logic          publish_complete;
    logic          malformed;
  } mqtt_df_res_t;

endpackage

@@ rtl/mqtt_df_if.sv @@
// ---------------------------------------------------------------------------
// MQTT deframer channel interfaces
// Valid/ready channels for received bytes and tagged result items.
// ---------------------------------------------------------------------------
interface mqtt_df_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mqtt_df_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_role;
  logic [3:0] packet_type;
  logic [3:0] packet_flags;
  logic       end_of_packet;
  logic       publish_complete;
  logic       malformed;

  modport source (output valid, output out_byte, output byte_role, output packet_type,
                  output packet_flags, output end_of_packet, output publish_complete,
                  output malformed, input ready);
  modport sink (input valid, input out_byte, input byte_role, input packet_type,
                input packet_flags, input end_of_packet, input publish_complete,
                input malformed, output ready);
endinterface

@@ rtl/mqtt_df_parse.sv @@
// ---------------------------------------------------------------------------
// MQTT deframer parser
// Parse state and per-byte tagging; state advances when an item moves on.
// ---------------------------------------------------------------------------
module mqtt_df_parse #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [7:0]                rx_byte,
  output mqtt_df_pkg::mqtt_df_res_t res
);
  import mqtt_df_pkg::*;

  localparam logic [2:0] MAX_LEN = 3'(MAX_LENGTH_BYTES);

  mqtt_df_phase_t      phase_r, phase_nxt;
  logic [3:0]          type_r, type_nxt;
  logic [3:0]          flags_r, flags_nxt;
  logic [BODY_W-1:0]   body_r, body_nxt;
  logic [1:0]          lidx_r, lidx_nxt;
  logic [15:0]         topic_r, topic_nxt;
  logic [7:0]          tlen_hi_r, tlen_hi_nxt;

  logic [BODY_W-1:0]   len_grp;
  logic [BODY_W-1:0]   len_sum;
  logic [BODY_W-1:0]   body_dec;
  logic [2:0]          lidx_inc;
  logic                too_long;
  logic                is_pub;
  logic [15:0]         tlen;
  logic                topic_over;
  logic [15:0]         topic_dec;
  mqtt_df_role_t       role;
  logic                eop;
  logic                pub;
  logic                bad;

  always_comb begin
    case (lidx_r)
      2'd0:    len_grp = {21'd0, rx_byte[6:0]};
      2'd1:    len_grp = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    len_grp = {7'd0, rx_byte[6:0], 14'd0};
      default: len_grp = {rx_byte[6:0], 21'd0};
    endcase
  end

  assign len_sum    = body_r + len_grp;
  assign body_dec   = body_r - BODY_W'(1);
  assign lidx_inc   = {1'b0, lidx_r} + 3'd1;
  assign too_long   = lidx_inc >= MAX_LEN;
  assign is_pub     = type_r == PUBLISH_TYPE;
  assign tlen       = {tlen_hi_r, rx_byte};
  assign topic_over = {12'd0, tlen} > body_dec;
  assign topic_dec  = topic_r - 16'd1;

  always_comb begin
    phase_nxt   = phase_r;
    type_nxt    = type_r;
    flags_nxt   = flags_r;
    body_nxt    = body_r;
    lidx_nxt    = lidx_r;
    topic_nxt   = topic_r;
    tlen_hi_nxt = tlen_hi_r;
    case (phase_r)
      PH_LENGTH: begin
        body_nxt = len_sum;
        if (rx_byte[7]) begin
          if (too_long) begin
            phase_nxt = PH_HEADER;
          end else begin
            lidx_nxt = lidx_inc[1:0];
          end
        end else if (is_pub) begin
          phase_nxt = (len_sum < BODY_W'(2)) ? PH_HEADER : PH_TOPIC_HI;
        end else begin
          phase_nxt = (len_sum == '0) ? PH_HEADER : PH_SKIP;
        end
      end
      PH_TOPIC_HI: begin
        tlen_hi_nxt = rx_byte;
        body_nxt    = body_dec;
        phase_nxt   = PH_TOPIC_LO;
      end
      PH_TOPIC_LO: begin
        body_nxt = body_dec;
        if (topic_over) begin
          phase_nxt = PH_HEADER;
        end else begin
          topic_nxt = tlen;
          if (body_dec == '0) begin
            phase_nxt = PH_HEADER;
          end else begin
            phase_nxt = (tlen != 16'd0) ? PH_TOPIC : PH_PAYLOAD;
          end
        end
      end
      PH_TOPIC: begin
        topic_nxt = topic_dec;
        body_nxt  = body_dec;
        if (body_dec == '0) begin
          phase_nxt = PH_HEADER;
        end else if (topic_dec == 16'd0) begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD, PH_SKIP: begin
        body_nxt = body_dec;
        if (body_dec == '0) begin
          phase_nxt = PH_HEADER;
        end
      end
      default: begin
        type_nxt    = rx_byte[7:4];
        flags_nxt   = rx_byte[3:0];
        body_nxt    = '0;
        lidx_nxt    = 2'd0;
        topic_nxt   = 16'd0;
        tlen_hi_nxt = 8'd0;
        phase_nxt   = PH_LENGTH;
      end
    endcase
  end

  always_comb begin
    role = ROLE_HEADER;
    eop  = 1'b0;
    pub  = 1'b0;
    bad  = 1'b0;
    case (phase_r)
      PH_LENGTH: begin
        bad = (rx_byte[7] && too_long) ||
              (!rx_byte[7] && is_pub && (len_sum < BODY_W'(2)));
        eop = !rx_byte[7] && !is_pub && (len_sum == '0);
      end
      PH_TOPIC_LO: begin
        bad = topic_over;
        eop = !topic_over && (body_dec == '0);
        pub = !topic_over && (body_dec == '0);
      end
      PH_TOPIC: begin
        role = ROLE_TOPIC;
        eop  = body_dec == '0;
        pub  = body_dec == '0;
      end
      PH_PAYLOAD: begin
        role = ROLE_PAYLOAD;
        eop  = body_dec == '0;
        pub  = body_dec == '0;
      end
      PH_SKIP: begin
        role = ROLE_SKIP;
        eop  = body_dec == '0;
      end
      default: begin
        role = ROLE_HEADER;
      end
    endcase
  end

  always_comb begin
    res.out_byte         = rx_byte;
    res.byte_role        = role;
    res.packet_type      = type_nxt;
    res.packet_flags     = flags_nxt;
    res.end_of_packet    = eop;
    res.publish_complete = pub;
    res.malformed        = bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      type_r    <= 4'd0;
      flags_r   <= 4'd0;
      body_r    <= '0;
      lidx_r    <= 2'd0;
      topic_r   <= 16'd0;
      tlen_hi_r <= 8'd0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      type_r    <= type_nxt;
      flags_r   <= flags_nxt;
      body_r    <= body_nxt;
      lidx_r    <= lidx_nxt;
      topic_r   <= topic_nxt;
      tlen_hi_r <= tlen_hi_nxt;
    end
  end

  a_bad_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    res.malformed |-> !res.end_of_packet && !res.publish_complete)
    else $error("malformed item also flags packet end");

  a_pub_is_publish: assert property (@(posedge clk) disable iff (!rst_n)
    res.publish_complete |-> res.end_of_packet && (res.packet_type == PUBLISH_TYPE))
    else $error("publish completion outside a PUBLISH end");

  a_resync: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (res.end_of_packet || res.malformed)) |=> (phase_r == PH_HEADER))
    else $error("parser did not return to header");

  a_topic_in_publish: assert property (@(posedge clk) disable iff (!rst_n)
    (res.byte_role == ROLE_TOPIC || res.byte_role == ROLE_PAYLOAD) |-> is_pub)
    else $error("topic or payload byte outside a PUBLISH");

endmodule

@@ rtl/mqtt_inbound_packet_deframer.sv @@
// An accepted byte passes the input register and then the result register before its result shows.
// Throughput: one byte per cycle while the output is taken; the parse loop is combinational around the state registers.
// The input register takes a new byte while a finished result still waits at the output.
// Reset (rst_n low, synchronous): parser returns to awaiting a header byte, both stages empty.
// ---------------------------------------------------------------------------
// MQTT inbound packet deframer
// Tags each received byte with its role in an MQTT 3.1.1 packet.
// ---------------------------------------------------------------------------
module mqtt_inbound_packet_deframer #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  mqtt_df_in_if.sink    in_chan,
  mqtt_df_out_if.source out_chan
);
  import mqtt_df_pkg::*;

  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic         out_valid_r, out_valid_nxt;
  mqtt_df_res_t out_res_r;
  mqtt_df_res_t res;
  logic         in_acc;
  logic         s1_adv;
  logic         out_take;

  assign out_take      = out_valid_r && out_chan.ready;
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_take);

  mqtt_df_parse #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (s1_adv),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_chan.rx_byte;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.out_byte         = out_res_r.out_byte;
  assign out_chan.byte_role        = out_res_r.byte_role;
  assign out_chan.packet_type      = out_res_r.packet_type;
  assign out_chan.packet_flags     = out_res_r.packet_flags;
  assign out_chan.end_of_packet    = out_res_r.end_of_packet;
  assign out_chan.publish_complete = out_res_r.publish_complete;
  assign out_chan.malformed        = out_res_r.malformed;

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// MQTT inbound deframer testbench
// Feeds byte streams through the deframer and checks every tagged result.
// A short directed sequence covers empty bodies, skipped bodies and each
// framing error. Random packet streams with noise follow. An in-house parser
// predicts each result, and both sides of the stream stall at random.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mqtt_df_pkg::*;

  localparam int MAX_LEN_BYTES = 4;
  localparam int DIR_N = 26;
  localparam int RAND_N = 500;
  localparam int QUIET_LO = 150;
  localparam int QUIET_HI = 270;
  localparam int PAUSE_AT = 300;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 80;
  localparam int BODY_CAP = 64;

  typedef struct packed {
    mqtt_df_phase_t phase;
    logic [3:0]     ptype;
    logic [3:0]     pflags;
    logic [27:0]    body_left;
    logic [1:0]     len_idx;
    logic [15:0]    topic_left;
    logic [7:0]     topic_hi;
  } parser_state_t;

  typedef struct packed {
    logic [7:0]    rx;
    logic          typed;
    mqtt_df_role_t role;
    logic [3:0]    ptype;
    logic [3:0]    pflags;
    logic          eop;
    logic          pub;
    logic          bad;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic quiet;
  logic hold_go;
  logic hold_active;

  parser_state_t gen_st;
  parser_state_t pred_st;
  logic [7:0]    byte_q[$];
  mqtt_df_res_t  pending_tags[$];

  int fail_cnt;
  int checked_cnt;
  int eop_cnt;
  int pub_cnt;
  int bad_cnt;

  dir_row_t dir_tab [DIR_N] = '{
    // empty body
    '{8'hC0, 1'b1, ROLE_HEADER, 4'hC, 4'h0, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, ROLE_HEADER, 4'hC, 4'h0, 1'b1, 1'b0, 1'b0},
    // skipped body, all-ones header
    '{8'hFF, 1'b1, ROLE_HEADER, 4'hF, 4'hF, 1'b0, 1'b0, 1'b0},
    '{8'h01, 1'b1, ROLE_HEADER, 4'hF, 4'hF, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, ROLE_SKIP,   4'hF, 4'hF, 1'b1, 1'b0, 1'b0},
    // varint too long
    '{8'h10, 1'b1, ROLE_HEADER, 4'h1, 4'h0, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, ROLE_HEADER, 4'h1, 4'h0, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, ROLE_HEADER, 4'h1, 4'h0, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, ROLE_HEADER, 4'h1, 4'h0, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, ROLE_HEADER, 4'h1, 4'h0, 1'b0, 1'b0, 1'b1},
    // short publish
    '{8'h30, 1'b1, ROLE_HEADER, 4'h3, 4'h0, 1'b0, 1'b0, 1'b0},
    '{8'h01, 1'b1, ROLE_HEADER, 4'h3, 4'h0, 1'b0, 1'b0, 1'b1},
    // topic longer than body
    '{8'h32, 1'b1, ROLE_HEADER, 4'h3, 4'h2, 1'b0, 1'b0, 1'b0},
    '{8'h03, 1'b1, ROLE_HEADER, 4'h3, 4'h2, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, ROLE_HEADER, 4'h3, 4'h2, 1'b0, 1'b0, 1'b0},
    '{8'h02, 1'b1, ROLE_HEADER, 4'h3, 4'h2, 1'b0, 1'b0, 1'b1},
    // publish ends after topic length
    '{8'h30, 1'b1, ROLE_HEADER, 4'h3, 4'h0, 1'b0, 1'b0, 1'b0},
    '{8'h02, 1'b1, ROLE_HEADER, 4'h3, 4'h0, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, ROLE_HEADER, 4'h3, 4'h0, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, ROLE_HEADER, 4'h3, 4'h0, 1'b1, 1'b1, 1'b0},
    // topic and payload
    '{8'h3F, 1'b0, ROLE_HEADER, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0},
    '{8'h04, 1'b0, ROLE_HEADER, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, ROLE_HEADER, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0},
    '{8'h01, 1'b0, ROLE_HEADER, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0},
    '{8'h61, 1'b0, ROLE_HEADER, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, ROLE_HEADER, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0}
  };

  mqtt_df_in_if  in_chan ();
  mqtt_df_out_if out_chan ();

  mqtt_inbound_packet_deframer #(
    .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  function automatic mqtt_df_res_t deframe_byte(inout parser_state_t st, input logic [7:0] b);
    mqtt_df_res_t r;
    logic [1:0]   idx;
    logic [15:0]  tlen;
    r = '0;
    r.out_byte = b;
    r.byte_role = ROLE_HEADER;
    case (st.phase)
      PH_LENGTH: begin
        idx = st.len_idx;
        st.body_left = st.body_left + ({21'd0, b[6:0]} << (7 * idx));
        if (b[7]) begin
          if (int'(idx) + 1 >= MAX_LEN_BYTES) begin
            r.malformed = 1'b1;
            st.phase = PH_HEADER;
          end else begin
            st.len_idx = idx + 2'd1;
          end
        end else if (st.ptype == PUBLISH_TYPE) begin
          if (st.body_left < 28'd2) begin
            r.malformed = 1'b1;
            st.phase = PH_HEADER;
          end else begin
            st.phase = PH_TOPIC_HI;
          end
        end else if (st.body_left == 28'd0) begin
          r.end_of_packet = 1'b1;
          st.phase = PH_HEADER;
        end else begin
          st.phase = PH_SKIP;
        end
      end
      PH_TOPIC_HI: begin
        st.topic_hi = b;
        st.body_left = st.body_left - 28'd1;
        st.phase = PH_TOPIC_LO;
      end
      PH_TOPIC_LO: begin
        tlen = {st.topic_hi, b};
        st.body_left = st.body_left - 28'd1;
        if ({12'd0, tlen} > st.body_left) begin
          r.malformed = 1'b1;
          st.phase = PH_HEADER;
        end else begin
          st.topic_left = tlen;
          if (st.body_left == 28'd0) begin
            r.end_of_packet = 1'b1;
            r.publish_complete = 1'b1;
            st.phase = PH_HEADER;
          end else begin
            st.phase = (tlen != 16'd0) ? PH_TOPIC : PH_PAYLOAD;
          end
        end
      end
      PH_TOPIC: begin
        r.byte_role = ROLE_TOPIC;
        st.topic_left = st.topic_left - 16'd1;
        st.body_left = st.body_left - 28'd1;
        if (st.body_left == 28'd0) begin
          r.end_of_packet = 1'b1;
          r.publish_complete = 1'b1;
          st.phase = PH_HEADER;
        end else if (st.topic_left == 16'd0) begin
          st.phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.byte_role = ROLE_PAYLOAD;
        st.body_left = st.body_left - 28'd1;
        if (st.body_left == 28'd0) begin
          r.end_of_packet = 1'b1;
          r.publish_complete = 1'b1;
          st.phase = PH_HEADER;
        end
      end
      PH_SKIP: begin
        r.byte_role = ROLE_SKIP;
        st.body_left = st.body_left - 28'd1;
        if (st.body_left == 28'd0) begin
          r.end_of_packet = 1'b1;
          st.phase = PH_HEADER;
        end
      end
      default: begin
        st.ptype = b[7:4];
        st.pflags = b[3:0];
        st.body_left = '0;
        st.len_idx = '0;
        st.topic_left = '0;
        st.topic_hi = '0;
        st.phase = PH_LENGTH;
      end
    endcase
    r.packet_type = st.ptype;
    r.packet_flags = st.pflags;
    return r;
  endfunction

  function automatic string tag_str(mqtt_df_res_t t);
    return $sformatf("byte %02h role %0d type %0h flags %0h eop %0b pub %0b bad %0b",
                     t.out_byte, t.byte_role, t.packet_type, t.packet_flags,
                     t.end_of_packet, t.publish_complete, t.malformed);
  endfunction

  task automatic flag_error(input string what);
    fail_cnt++;
    if (fail_cnt <= 10) $display("ERROR: %s", what);
  endtask

  task automatic emit(input logic [7:0] b);
    byte_q.push_back(b);
    void'(deframe_byte(gen_st, b));
  endtask

  // keep noise from opening a long body
  task automatic emit_noise(input logic [7:0] b);
    parser_state_t probe;
    probe = gen_st;
    void'(deframe_byte(probe, b));
    if (probe.phase != PH_HEADER && probe.body_left > BODY_CAP) b = 8'h00;
    emit(b);
  endtask

  task automatic emit_length(input int unsigned len);
    int unsigned groups;
    int unsigned total;
    int unsigned i;
    groups = 1;
    while (groups < 4 && (len >> (7 * groups)) != 0) groups++;
    total = groups;
    if ($urandom_range(9) == 0) total = $urandom_range(4, groups);
    for (i = 0; i < total; i++) emit({(i + 1 < total), 7'((len >> (7 * i)) & 127)});
  endtask

  task automatic build_stream();
    int          i;
    int unsigned pick;
    int unsigned body;
    int unsigned plen;
    logic [15:0] tlen;
    logic [3:0]  flags;
    logic [3:0]  ptype;
    gen_st = '0;
    gen_st.phase = PH_HEADER;
    for (i = 0; i < DIR_N; i++) emit(dir_tab[i].rx);
    while (byte_q.size() < DIR_N + RAND_N) begin
      pick = $urandom_range(99);
      flags = 4'($urandom_range(15));
      if (pick < 45) begin
        tlen = 16'($urandom_range(6));
        plen = ($urandom_range(24) == 0) ? $urandom_range(180, 120) : $urandom_range(8);
        emit({PUBLISH_TYPE, flags});
        emit_length(2 + tlen + plen);
        emit(tlen[15:8]);
        emit(tlen[7:0]);
        repeat (tlen + plen) emit(8'($urandom_range(255)));
      end else if (pick < 75) begin
        ptype = 4'($urandom_range(14));
        if (ptype >= PUBLISH_TYPE) ptype++;
        body = $urandom_range(10);
        emit({ptype, flags});
        emit_length(body);
        repeat (body) emit(8'($urandom_range(255)));
      end else if (pick < 88) begin
        case ($urandom_range(2))
          0: begin
            emit({PUBLISH_TYPE, flags});
            emit_length($urandom_range(1));
          end
          1: begin
            body = $urandom_range(8, 2);
            tlen = $urandom_range(1) ? 16'($urandom_range(body + 3, body - 1))
                                     : 16'($urandom_range(65535, 256));
            emit({PUBLISH_TYPE, flags});
            emit_length(body);
            emit(tlen[15:8]);
            emit(tlen[7:0]);
          end
          default: begin
            emit(8'($urandom_range(255)));
            repeat (4) emit(8'h80 | 8'($urandom_range(127)));
          end
        endcase
      end else begin
        repeat ($urandom_range(6, 1)) emit_noise(8'($urandom_range(255)));
        while (gen_st.phase != PH_HEADER) emit_noise(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2ms;
    $display("FAIL mqtt_inbound_packet_deframer");
    $finish;
  end

  initial begin
    hold_active = 1'b0;
    wait (hold_go === 1'b1);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n || hold_active) begin
        out_chan.ready <= 1'b0;
      end else if (quiet) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= 29);
      end
    end
  end

  always @(posedge clk) begin : result_check
    mqtt_df_res_t got;
    mqtt_df_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.out_byte = out_chan.out_byte;
      got.byte_role = mqtt_df_role_t'(out_chan.byte_role);
      got.packet_type = out_chan.packet_type;
      got.packet_flags = out_chan.packet_flags;
      got.end_of_packet = out_chan.end_of_packet;
      got.publish_complete = out_chan.publish_complete;
      got.malformed = out_chan.malformed;
      checked_cnt++;
      eop_cnt += got.end_of_packet;
      pub_cnt += got.publish_complete;
      bad_cnt += got.malformed;
      if (pending_tags.size() == 0) begin
        flag_error({"unexpected result: ", tag_str(got)});
      end else begin
        want = pending_tags.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_role !== want.byte_role ||
            got.packet_type !== want.packet_type || got.packet_flags !== want.packet_flags ||
            got.end_of_packet !== want.end_of_packet ||
            got.publish_complete !== want.publish_complete ||
            got.malformed !== want.malformed) begin
          flag_error({"got ", tag_str(got), " / want ", tag_str(want)});
        end
      end
    end
  end

  initial begin : byte_source
    int           i;
    mqtt_df_res_t r;
    in_chan.valid = 1'b0;
    in_chan.rx_byte = 8'h00;
    quiet = 1'b0;
    hold_go = 1'b0;
    fail_cnt = 0;
    checked_cnt = 0;
    eop_cnt = 0;
    pub_cnt = 0;
    bad_cnt = 0;
    pred_st = '0;
    pred_st.phase = PH_HEADER;
    build_stream();
    wait (rst_n === 1'b1);
    @(posedge clk);
    for (i = 0; i < byte_q.size(); i++) begin
      quiet <= (i >= QUIET_LO && i < QUIET_HI);
      if (i == PAUSE_AT) begin
        in_chan.valid <= 1'b0;
        do @(posedge clk); while (pending_tags.size() != 0);
      end
      while (!(i >= QUIET_LO && i < QUIET_HI) && $urandom_range(99) < 29) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
      end
      in_chan.valid <= 1'b1;
      in_chan.rx_byte <= byte_q[i];
      do @(posedge clk); while (!in_chan.ready);
      r = deframe_byte(pred_st, byte_q[i]);
      if (i < DIR_N && dir_tab[i].typed) begin
        r.byte_role = dir_tab[i].role;
        r.packet_type = dir_tab[i].ptype;
        r.packet_flags = dir_tab[i].pflags;
        r.end_of_packet = dir_tab[i].eop;
        r.publish_complete = dir_tab[i].pub;
        r.malformed = dir_tab[i].bad;
      end
      pending_tags.push_back(r);
      if (i == HOLD_AT) hold_go <= 1'b1;
    end
    in_chan.valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (pending_tags.size() != 0) flag_error("results still outstanding at end of run");
    $display("Sent %0d bytes (%0d directed), checked %0d results, %0d errors",
             byte_q.size(), DIR_N, checked_cnt, fail_cnt);
    $display("Seen %0d packet ends, %0d publish completions, %0d framing errors",
             eop_cnt, pub_cnt, bad_cnt);
    if (fail_cnt == 0) begin
      $display("PASS mqtt_inbound_packet_deframer");
    end else begin
      $display("FAIL mqtt_inbound_packet_deframer");
    end
    $finish;
  end

endmodule
